### rtl/drps_pkg.sv
// ----------------------------------------------------------------------------
// drps_pkg
// Shared types, register codes, symbol mapping and the root-raised-cosine
// tap table of the 4FSK pulse shaper.
// ----------------------------------------------------------------------------
package drps_pkg;

  localparam int TABLE_TAPS = 150;
  localparam int HALF_TAPS  = 75;
  localparam int BASE_WIDTH = 18;
  localparam logic [15:0] GAIN_RESET = 16'd7168;
  localparam int QUEUE_DEPTH = 2;

  // first half of the symmetric pulse, q2.16, last entry is the peak
  localparam int HALF_TAP_TABLE [HALF_TAPS] = '{
    192, 206, 177, 109, 15, -84, -168, -215, -214, -162,
    -67, 51, 167, 255, 292, 265, 175, 38, -121, -268,
    -370, -402, -351, -223, -42, 155, 325, 426, 431, 328,
    132, -120, -375, -573, -662, -607, -402, -74, 321, 702,
    987, 1101, 1000, 683, 199, -363, -878, -1219, -1275, -983,
    -353, 528, 1495, 2327, 2781, 2638, 1751, 91, -2225, -4917,
    -7563, -9636, -10564, -9810, -6954, -1764, 5740, 15266, 26254, 37921,
    49337, 59524, 67565, 72716, 74490
  };

  typedef enum logic {
    REG_INVERT = 1'b0,
    REG_GAIN   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        invert;
    logic [15:0] gain;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic signed [2:0] sym;
  } sym_t;

  // dibit to 4fsk level, flush gives the zero symbol
  function automatic logic signed [2:0] map_symbol(input logic [1:0] dibit,
                                                   input logic flush);
    logic signed [2:0] s;
    unique case (dibit)
      2'd0:    s = 3'sd1;
      2'd1:    s = 3'sd3;
      2'd2:    s = -3'sd1;
      default: s = -3'sd3;
    endcase
    return flush ? 3'sd0 : s;
  endfunction

  // tap value rescaled to tap_width-2 fraction bits, zero beyond the table
  function automatic int tap_value(input int idx, input int tap_count,
                                   input int tap_width);
    int t;
    if (idx >= tap_count || idx >= TABLE_TAPS - 1) begin
      t = 0;
    end else if (idx < HALF_TAPS) begin
      t = HALF_TAP_TABLE[idx];
    end else begin
      t = HALF_TAP_TABLE[2 * (HALF_TAPS - 1) - idx];
    end
    if (tap_width >= BASE_WIDTH) begin
      return t <<< (tap_width - BASE_WIDTH);
    end
    // round half up
    return (t + (1 <<< (BASE_WIDTH - 1 - tap_width))) >>> (BASE_WIDTH - tap_width);
  endfunction

endpackage

### rtl/drps_regs.sv
// ----------------------------------------------------------------------------
// drps_regs
// APB-style register file holding the output inversion and gain settings.
// ----------------------------------------------------------------------------
module drps_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output drps_pkg::cfg_t     cfg_o
);

  logic        invert_q;
  logic [15:0] gain_q;
  logic        wr_en;
  drps_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  // word addressed, byte offset bits ignored
  assign idx    = drps_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      gain_q   <= drps_pkg::GAIN_RESET;
    end else if (wr_en) begin
      unique case (idx)
        drps_pkg::REG_INVERT: invert_q <= pwdata[0];
        drps_pkg::REG_GAIN:   gain_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      drps_pkg::REG_INVERT: prdata = {31'b0, invert_q};
      drps_pkg::REG_GAIN:   prdata = {16'b0, gain_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.invert = invert_q;
  assign cfg_o.gain   = gain_q;

endmodule

### rtl/drps_front.sv
// ----------------------------------------------------------------------------
// drps_front
// Input side: maps each dibit or flush to a 4FSK level and queues the
// symbol for the filter back end.
// ----------------------------------------------------------------------------
module drps_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     dibit_i,
  input  logic           flush_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output drps_pkg::sym_t sym_o,
  input  logic           pop_i
);

  localparam int CW = $clog2(drps_pkg::QUEUE_DEPTH + 1);
  localparam int PW = $clog2(drps_pkg::QUEUE_DEPTH);

  logic signed [2:0] mem_q [drps_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              push;

  assign in_ready_o = count_q < CW'(drps_pkg::QUEUE_DEPTH);
  assign push       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= drps_pkg::map_symbol(dibit_i, flush_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CW'(push) - CW'(pop_i);
    end
  end

  assign sym_o.valid = count_q != '0;
  assign sym_o.sym   = mem_q[rd_ptr_q];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(drps_pkg::QUEUE_DEPTH))
    else $error("symbol queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty symbol queue");
`endif

endmodule

### rtl/drps_back.sv
// ----------------------------------------------------------------------------
// drps_back
// Filter back end: symbol history, polyphase branch sequencer and the
// pipelined multiply-accumulate, gain, rounding and saturation path.
// ----------------------------------------------------------------------------
module drps_back #(
  parameter int TAP_COUNT = 150,
  parameter int UPSAMPLE  = 10,
  parameter int TAP_WIDTH = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drps_pkg::sym_t     sym_i,
  output logic               pop_o,
  input  drps_pkg::cfg_t     cfg_i,
  output logic signed [15:0] sample_o,
  output logic               last_sample_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  localparam int DEPTH  = (TAP_COUNT + UPSAMPLE - 1) / UPSAMPLE;
  localparam int PW     = $clog2(UPSAMPLE);
  localparam int PRODW  = TAP_WIDTH + 2;
  localparam int GROUPS = (DEPTH + 3) / 4;
  localparam int GW     = PRODW + 2;
  localparam int AW     = GW + $clog2(GROUPS) + 1;
  localparam int MW     = AW + 17;
  localparam int SH     = TAP_WIDTH - 2;
  localparam int QW     = MW - SH;

  logic signed [TAP_WIDTH-1:0] coef [UPSAMPLE][DEPTH];

  for (genvar gp = 0; gp < UPSAMPLE; gp++) begin : g_phase
    for (genvar gj = 0; gj < DEPTH; gj++) begin : g_tap
      localparam int TV = drps_pkg::tap_value(gp + UPSAMPLE * gj, TAP_COUNT, TAP_WIDTH);
      assign coef[gp][gj] = TAP_WIDTH'(TV);
    end
  end

  // sequencer and history
  logic signed [2:0] hist_q [DEPTH];
  logic [PW-1:0]     phase_q;
  logic              busy_q;
  logic              en;
  logic              last_phase;

  logic              out_valid_q;
  logic signed [15:0] sample_q;
  logic              out_last_q;

  // whole pipeline advances when the output register can take a sample
  assign en         = ~out_valid_q | out_ready_i;
  assign last_phase = phase_q == PW'(UPSAMPLE - 1);
  assign pop_o      = en & sym_i.valid & (~busy_q | last_phase);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= '0;
      for (int j = 0; j < DEPTH; j++) begin
        hist_q[j] <= 3'sd0;
      end
    end else if (en) begin
      if (busy_q && !last_phase) begin
        phase_q <= phase_q + PW'(1);
      end else begin
        busy_q  <= sym_i.valid;
        phase_q <= '0;
      end
      if (pop_o) begin
        for (int j = DEPTH - 1; j > 0; j--) begin
          hist_q[j] <= hist_q[j - 1];
        end
        hist_q[0] <= sym_i.sym;
      end
    end
  end

  // stage 1: products of the selected branch, summed in groups of four
  logic signed [PRODW-1:0] prod [DEPTH];
  logic signed [GW-1:0]    grp_d [GROUPS];
  logic signed [GW-1:0]    grp_q [GROUPS];
  logic                    s1_valid_q, s1_last_q;

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      prod[j] = PRODW'(coef[phase_q][j]) * PRODW'(hist_q[j]);
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < DEPTH) begin
          grp_d[g] = grp_d[g] + GW'(prod[g * 4 + k]);
        end
      end
    end
  end

  // stage 2: full branch sum
  logic signed [AW-1:0] acc_d, acc_q;
  logic                 s2_valid_q, s2_last_q;

  always_comb begin
    acc_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      acc_d = acc_d + AW'(grp_q[g]);
    end
  end

  // stage 3: gain
  logic signed [MW-1:0] mul_d, mul_q;
  logic signed [16:0]   gain_s;
  logic                 s3_valid_q, s3_last_q;

  assign gain_s = {1'b0, cfg_i.gain};
  assign mul_d  = MW'(acc_q) * MW'(gain_s);

  // stage 4: drop fraction bits, truncating toward zero
  logic signed [MW-1:0] bias, biased;
  logic signed [QW-1:0] quo_q;
  logic                 s4_valid_q, s4_last_q;

  assign bias   = mul_q[MW-1] ? {{(MW - SH){1'b0}}, {SH{1'b1}}} : '0;
  assign biased = mul_q + bias;

  // output stage: inversion and int16 saturation
  logic signed [QW:0]  neg;
  logic                pos_ovf, neg_ovf;
  logic signed [15:0]  sat;

  assign neg     = cfg_i.invert ? -(QW + 1)'(quo_q) : (QW + 1)'(quo_q);
  assign pos_ovf = ~neg[QW] & (|neg[QW-1:15]);
  assign neg_ovf = neg[QW] & ~(&neg[QW-1:15]);

  always_comb begin
    priority if (pos_ovf) begin
      sat = 16'sh7fff;
    end else if (neg_ovf) begin
      sat = 16'sh8000;
    end else begin
      sat = neg[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      grp_q    <= grp_d;
      acc_q    <= acc_d;
      mul_q    <= mul_d;
      quo_q    <= QW'(biased >>> SH);
      sample_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      s3_valid_q  <= 1'b0;
      s3_last_q   <= 1'b0;
      s4_valid_q  <= 1'b0;
      s4_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= busy_q;
      s1_last_q   <= busy_q & last_phase;
      s2_valid_q  <= s1_valid_q;
      s2_last_q   <= s1_last_q;
      s3_valid_q  <= s2_valid_q;
      s3_last_q   <= s2_last_q;
      s4_valid_q  <= s3_valid_q;
      s4_last_q   <= s3_last_q;
      out_valid_q <= s4_valid_q;
      out_last_q  <= s4_last_q;
    end
  end

  assign sample_o      = sample_q;
  assign last_sample_o = out_last_q;
  assign out_valid_o   = out_valid_q;

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> phase_q <= PW'(UPSAMPLE - 1))
    else $error("branch phase out of range");

  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> phase_q == '0)
    else $error("phase not parked while idle");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_last_q |-> s4_valid_q)
    else $error("last flag without a sample in the pipeline");
`endif

endmodule

### rtl/dibit_rrc_pulse_shaper_unit.sv
// ----------------------------------------------------------------------------
// dibit_rrc_pulse_shaper_unit
// 4FSK root-raised-cosine pulse shaper: one dibit in, ten shaped samples out.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i/in_ready_o) carries one dibit, or a flush that
//   inserts the zero symbol. Each transfer yields UPSAMPLE output samples on
//   the output channel (out_valid_o/out_ready_i), the final one flagged by
//   last_sample_o.
//   path: a symbol passes from the queue into the history register, then
//   through the group sum, branch sum, gain, quotient and output registers.
//   throughput: one sample per cycle while the output is not stalled, set by the
//   single multiply-accumulate path that evaluates one polyphase branch of
//   DEPTH taps per cycle. A two-entry symbol queue lets the input side keep
//   taking symbols while the filter is busy.
//   stall: when out_ready_i is low while a sample waits in the output register,
//   the whole filter pipeline holds; the queue fills and in_ready_o then drops.
//   reset: symbol history cleared to zero symbols, gain 7168, no inversion.
//   registers (APB, byte address): 0x0 invert_output, 0x4 output_gain; write
//   them only while no symbol is in flight.
// ----------------------------------------------------------------------------
module dibit_rrc_pulse_shaper_unit #(
  parameter int TAP_COUNT = 150,
  parameter int UPSAMPLE  = 10,
  parameter int TAP_WIDTH = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic [1:0]         dibit_i,
  input  logic               flush_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic signed [15:0] sample_o,
  output logic               last_sample_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  drps_pkg::cfg_t cfg;
  drps_pkg::sym_t sym;
  logic           pop;

  drps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  drps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dibit_i    (dibit_i),
    .flush_i    (flush_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sym_o      (sym),
    .pop_i      (pop)
  );

  drps_back #(
    .TAP_COUNT (TAP_COUNT),
    .UPSAMPLE  (UPSAMPLE),
    .TAP_WIDTH (TAP_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sym_i         (sym),
    .pop_o         (pop),
    .cfg_i         (cfg),
    .sample_o      (sample_o),
    .last_sample_o (last_sample_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

### tb/dibit_rrc_pulse_shaper_unit_test.sv
// ----------------------------------------------------------------------------
// dibit_rrc_pulse_shaper_unit_test
// Feeds dibits and flushes into the 4FSK pulse shaper and checks each group
// of ten shaped samples against a local polyphase filter model. Covers the
// gain and inversion registers at their extremes, saturation, random idling
// on both channels and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module dibit_rrc_pulse_shaper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES        = 10;
  localparam int TAPS          = 150;
  localparam int DEPTH         = (TAPS + PHASES - 1) / PHASES;
  localparam int FRAC_BITS     = 16;
  localparam int RANDOM_ROUNDS = 4;
  localparam int ROUND_SYMBOLS = 47;
  localparam int QUIET_FROM    = 130;
  localparam int QUIET_TO      = 170;
  localparam int HOLD_AT       = 50;
  localparam int HOLD_CYCLES   = 90;
  localparam int DRAIN_CYCLES  = 12;
  localparam int DIRECTED_ROWS = 24;

  typedef struct packed {
    logic [1:0]         dibit;
    logic               flush;
    logic               invert;
    logic [15:0]        gain;
    logic               known;
    logic signed [15:0] known_level;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] level;
    logic               last;
  } shaped_t;

  // directed sequence; known rows carry the sample value all ten outputs take
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{2'd0, 1'b1, 1'b0, 16'd7168,  1'b1, 16'sd0},  // flush straight after reset
    '{2'd3, 1'b1, 1'b0, 16'd7168,  1'b1, 16'sd0},
    '{2'd0, 1'b0, 1'b0, 16'd7168,  1'b0, 16'sd0},
    '{2'd1, 1'b0, 1'b0, 16'd7168,  1'b0, 16'sd0},
    '{2'd2, 1'b0, 1'b0, 16'd7168,  1'b0, 16'sd0},
    '{2'd3, 1'b0, 1'b0, 16'd7168,  1'b0, 16'sd0},
    '{2'd3, 1'b1, 1'b0, 16'd7168,  1'b0, 16'sd0},  // dibit ignored on flush
    '{2'd1, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},  // full gain, saturates
    '{2'd1, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},
    '{2'd1, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},
    '{2'd1, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},
    '{2'd3, 1'b0, 1'b1, 16'd65535, 1'b0, 16'sd0},
    '{2'd3, 1'b0, 1'b1, 16'd65535, 1'b0, 16'sd0},
    '{2'd3, 1'b0, 1'b1, 16'd65535, 1'b0, 16'sd0},
    '{2'd3, 1'b0, 1'b1, 16'd65535, 1'b0, 16'sd0},
    '{2'd2, 1'b0, 1'b1, 16'd0,     1'b1, 16'sd0},  // zero gain
    '{2'd1, 1'b0, 1'b1, 16'd0,     1'b1, 16'sd0},
    '{2'd0, 1'b0, 1'b0, 16'd1,     1'b0, 16'sd0},
    '{2'd2, 1'b0, 1'b0, 16'd1,     1'b0, 16'sd0},
    '{2'd1, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},
    '{2'd3, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},
    '{2'd1, 1'b0, 1'b0, 16'd65535, 1'b0, 16'sd0},
    '{2'd0, 1'b1, 1'b0, 16'd7168,  1'b0, 16'sd0},
    '{2'd2, 1'b1, 1'b0, 16'd7168,  1'b0, 16'sd0}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic [1:0]         dibit_i     = '0;
  logic               flush_i     = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_o;
  logic               last_sample_o;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;

  // shaper model state
  logic signed [2:0]  symbol_line [DEPTH];
  logic               shaper_invert = 1'b0;
  logic [15:0]        shaper_gain   = drps_pkg::GAIN_RESET;
  shaped_t            pending_samples [$];

  int errors          = 0;
  int symbols_sent    = 0;
  int flushes_sent    = 0;
  int samples_checked = 0;
  int settings_used   = 1;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  dibit_rrc_pulse_shaper_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .dibit_i       (dibit_i),
    .flush_i       (flush_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_o      (sample_o),
    .last_sample_o (last_sample_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit quiet_window();
    return symbols_sent >= QUIET_FROM && symbols_sent < QUIET_TO;
  endfunction

  function automatic bit roll_idle();
    return !quiet_window() && ($urandom_range(99) < 28);
  endfunction

  function automatic int rrc_tap(input int idx);
    if (idx >= TAPS || idx >= 2 * drps_pkg::HALF_TAPS - 1) begin
      return 0;
    end
    if (idx < drps_pkg::HALF_TAPS) begin
      return drps_pkg::HALF_TAP_TABLE[idx];
    end
    return drps_pkg::HALF_TAP_TABLE[2 * (drps_pkg::HALF_TAPS - 1) - idx];
  endfunction

  function automatic logic signed [2:0] fsk_level(input logic [1:0] d, input logic f);
    if (f) begin
      return 3'sd0;
    end
    case (d)
      2'd0:    return 3'sd1;
      2'd1:    return 3'sd3;
      2'd2:    return -3'sd1;
      default: return -3'sd3;
    endcase
  endfunction

  // shift one symbol in and evaluate every polyphase branch
  function automatic void shape_symbol(input logic [1:0] d, input logic f,
                                       output logic signed [15:0] levels [PHASES]);
    longint acc;
    longint scaled;
    for (int j = DEPTH - 1; j > 0; j--) begin
      symbol_line[j] = symbol_line[j - 1];
    end
    symbol_line[0] = fsk_level(d, f);
    for (int p = 0; p < PHASES; p++) begin
      acc = 0;
      for (int j = 0; j < DEPTH; j++) begin
        acc += longint'(rrc_tap(p + PHASES * j)) * longint'(symbol_line[j]);
      end
      // signed division truncates toward zero
      scaled = (acc * longint'(shaper_gain)) / (longint'(1) << FRAC_BITS);
      if (shaper_invert) begin
        scaled = -scaled;
      end
      if (scaled > 32767) begin
        scaled = 32767;
      end else if (scaled < -32768) begin
        scaled = -32768;
      end
      levels[p] = scaled[15:0];
    end
  endfunction

  task automatic send_symbol(input logic [1:0] d, input logic f, input logic known,
                             input logic signed [15:0] known_level);
    logic signed [15:0] levels [PHASES];
    shaped_t            s;
    if (roll_idle()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (roll_idle());
    end
    in_valid_i <= 1'b1;
    dibit_i    <= d;
    flush_i    <= f;
    do @(posedge clk_i); while (!in_ready_o);
    shape_symbol(d, f, levels);
    for (int p = 0; p < PHASES; p++) begin
      s.level = known ? known_level : levels[p];
      s.last  = (p == PHASES - 1);
      pending_samples.push_back(s);
    end
    symbols_sent++;
    if (f) begin
      flushes_sent++;
    end
  endtask

  task automatic reg_access(input drps_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] width_mask;
    width_mask = (idx == drps_pkg::REG_INVERT) ? 32'h1 : 32'hFFFF;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == drps_pkg::REG_INVERT) begin
      shaper_invert = value[0];
    end else begin
      shaper_gain = value[15:0];
    end
    // read back
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & width_mask) != (value & width_mask)) begin
      $error("%s readback: expected %0h, got %0h", idx.name(), value & width_mask,
             prdata & width_mask);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // registers change only once every sample in flight has come out
  task automatic apply_settings(input logic inv, input logic [15:0] gain);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    // upper data bits carry noise, only the register width is kept
    reg_access(drps_pkg::REG_INVERT, {31'($urandom_range(32'h7FFF_FFFF)), inv});
    reg_access(drps_pkg::REG_GAIN, {16'($urandom_range(16'hFFFF)), gain});
    settings_used++;
  endtask

  // output side: check every transfer, then pick the next ready level
  always @(posedge clk_i) begin
    shaped_t s;
    if (out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample transfer: sample %0d last %0b", sample_o, last_sample_o);
        errors++;
      end else begin
        s = pending_samples.pop_front();
        samples_checked++;
        if (sample_o !== s.level) begin
          $error("sample: expected %0d, got %0d", s.level, sample_o);
          errors++;
        end
        if (last_sample_o !== s.last) begin
          $error("last_sample: expected %0b, got %0b", s.last, last_sample_o);
          errors++;
        end
      end
    end
    if (!hold_done && symbols_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !roll_idle();
    end
  end

  initial begin
    stim_row_t   row;
    logic        inv;
    logic [15:0] gain;
    logic [1:0]  d;
    logic        f;
    for (int j = 0; j < DEPTH; j++) begin
      symbol_line[j] = 3'sd0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.invert != shaper_invert || row.gain != shaper_gain) begin
        apply_settings(row.invert, row.gain);
      end
      send_symbol(row.dibit, row.flush, row.known, row.known_level);
    end

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      inv = 1'($urandom_range(1));
      case ($urandom_range(4))
        0:       gain = 16'hFFFF;
        1:       gain = 16'd1;
        2:       gain = drps_pkg::GAIN_RESET;
        default: gain = 16'($urandom_range(16'hFFFF));
      endcase
      apply_settings(inv, gain);
      for (int i = 0; i < ROUND_SYMBOLS; i++) begin
        d = 2'($urandom_range(3));
        f = ($urandom_range(7) == 0);
        send_symbol(d, f, 1'b0, 16'sd0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d symbols (%0d flushes) under %0d register settings", symbols_sent,
             flushes_sent, settings_used);
    $display("Checked %0d shaped samples, including a %0d-cycle output hold", samples_checked,
             HOLD_CYCLES);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/drps_pkg.sv
rtl/drps_regs.sv
rtl/drps_front.sv
rtl/drps_back.sv
rtl/dibit_rrc_pulse_shaper_unit.sv
tb/dibit_rrc_pulse_shaper_unit_test.sv
